FILE: design/lbsb_pkg.sv
package lbsb_pkg;

  localparam int OP_WIDTH  = 3;
  localparam int VAL_WIDTH = 32;
  localparam int CNT_WIDTH = 6;
  localparam int POS_WIDTH = 12;
  localparam int MAX_BITS  = 32;

  localparam logic [OP_WIDTH-1:0] OP_WRITE    = 3'd0;
  localparam logic [OP_WIDTH-1:0] OP_READ     = 3'd1;
  localparam logic [OP_WIDTH-1:0] OP_ALIGN_WR = 3'd2;
  localparam logic [OP_WIDTH-1:0] OP_ALIGN_RD = 3'd3;
  localparam logic [OP_WIDTH-1:0] OP_RESET_WR = 3'd4;
  localparam logic [OP_WIDTH-1:0] OP_RESET_RD = 3'd5;
  localparam logic [OP_WIDTH-1:0] OP_CLEAR    = 3'd6;

  typedef struct packed {
    logic load;
    logic issue;
    logic step;
    logic emit;
  } lbsb_cmd_t;

  typedef struct packed {
    logic done;
    logic out_free;
  } lbsb_status_t;

endpackage

FILE: design/lbsb_in_if.sv
interface lbsb_in_if;
  import lbsb_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OP_WIDTH-1:0]  operation;
  logic [VAL_WIDTH-1:0] value;
  logic [CNT_WIDTH-1:0] bit_count;

  modport source (output valid, operation, value, bit_count, input ready);
  modport sink (input valid, operation, value, bit_count, output ready);

endinterface

FILE: design/lbsb_out_if.sv
interface lbsb_out_if;
  import lbsb_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [VAL_WIDTH-1:0] read_value;
  logic                 error;
  logic [POS_WIDTH-1:0] write_position;
  logic [POS_WIDTH-1:0] read_position;

  modport source (output valid, read_value, error, write_position, read_position,
                  input ready);
  modport sink (input valid, read_value, error, write_position, read_position,
                output ready);

endinterface

FILE: design/lsb_first_bit_stream_buffer_top.sv
// A read or write word touches up to 5 bytes of the store; align, reset, clear and
// zero-count words touch none. A new word is taken only once the last one's result
// has been emitted, and the memory handles one byte read-modify-write per cycle.
// A result that is not taken holds the next word back for as long as it waits.
// Reset: synchronous active-low rst_n empties the store and zeroes both positions.
module lsb_first_bit_stream_buffer_top #(
  parameter int BUF_BYTES = 256
) (
  input logic              clk,
  input logic              rst_n,
  lbsb_in_if.sink          in_if,
  lbsb_out_if.source       out_if
);
  import lbsb_pkg::*;

  lbsb_cmd_t    cmd;
  lbsb_status_t st;

  lbsb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .st       (st),
    .cmd      (cmd)
  );

  lbsb_dp #(
    .BUF_BYTES (BUF_BYTES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .in_operation       (in_if.operation),
    .in_value           (in_if.value),
    .in_bit_count       (in_if.bit_count),
    .out_valid          (out_if.valid),
    .out_ready          (out_if.ready),
    .out_read_value     (out_if.read_value),
    .out_error          (out_if.error),
    .out_write_position (out_if.write_position),
    .out_read_position  (out_if.read_position)
  );

endmodule

FILE: design/lbsb_ctrl.sv
module lbsb_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lbsb_pkg::lbsb_status_t st,
  output lbsb_pkg::lbsb_cmd_t    cmd
);
  import lbsb_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_PROC  = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (st.done) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.issue = 1'b1;
          state_nxt = S_PROC;
        end
      end
      S_PROC: begin
        if (st.done) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: design/lbsb_dp.sv
module lbsb_dp #(
  parameter int BUF_BYTES = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lbsb_pkg::lbsb_cmd_t            cmd,
  output lbsb_pkg::lbsb_status_t         st,
  input  logic [lbsb_pkg::OP_WIDTH-1:0]  in_operation,
  input  logic [lbsb_pkg::VAL_WIDTH-1:0] in_value,
  input  logic [lbsb_pkg::CNT_WIDTH-1:0] in_bit_count,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [lbsb_pkg::VAL_WIDTH-1:0] out_read_value,
  output logic                           out_error,
  output logic [lbsb_pkg::POS_WIDTH-1:0] out_write_position,
  output logic [lbsb_pkg::POS_WIDTH-1:0] out_read_position
);
  import lbsb_pkg::*;

  localparam int PW = $clog2(BUF_BYTES * 8 + 1);
  localparam int UW = $clog2(BUF_BYTES + 1);
  localparam int IW = PW - 3;
  localparam int AW = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;

  logic [7:0] mem [BUF_BYTES];

  logic [OP_WIDTH-1:0]  op_r;
  logic [VAL_WIDTH-1:0] val_r;
  logic [CNT_WIDTH-1:0] rem_r;
  logic [CNT_WIDTH-1:0] got_r;
  logic [VAL_WIDTH-1:0] rv_r;
  logic                 err_r;
  logic [PW-1:0]        wpos_r;
  logic [PW-1:0]        rpos_r;
  logic [UW-1:0]        used_r;
  logic [7:0]           rdata_r;

  logic                 out_valid_r;
  logic [VAL_WIDTH-1:0] out_rv_r;
  logic                 out_err_r;
  logic [POS_WIDTH-1:0] out_wpos_r;
  logic [POS_WIDTH-1:0] out_rpos_r;

  logic                 is_wr;
  logic                 is_rd;
  logic [PW-1:0]        cur_pos;
  logic [IW-1:0]        idx;
  logic [2:0]           off;
  logic [3:0]           room;
  logic [3:0]           n;
  logic [7:0]           nmask;
  logic [7:0]           bmask;
  logic                 in_cap;
  logic                 in_used;
  logic [7:0]           base;
  logic [7:0]           wr_data;
  logic [7:0]           rd_bits;
  logic                 wr_en;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [CNT_WIDTH-1:0] cnt_sat;

  function automatic logic [PW-1:0] round_up8(input logic [PW-1:0] p);
    logic [IW-1:0] hi;
    hi = p[PW-1:3] + IW'(|p[2:0]);
    return {hi, 3'b000};
  endfunction

  assign is_wr   = (op_r == OP_WRITE);
  assign is_rd   = (op_r == OP_READ);
  assign cur_pos = is_wr ? wpos_r : rpos_r;
  assign idx     = cur_pos[PW-1:3];
  assign off     = cur_pos[2:0];
  assign room    = 4'd8 - {1'b0, off};
  assign n       = (rem_r < {2'b00, room}) ? rem_r[3:0] : room;
  assign nmask   = 8'((9'd1 << n) - 9'd1);
  assign bmask   = nmask << off;
  assign in_cap  = (idx < IW'(BUF_BYTES));
  assign in_used = (idx < IW'(used_r));
  assign base    = in_used ? rdata_r : 8'h00;
  assign wr_data = base | ((val_r[7:0] << off) & bmask);
  assign rd_bits = (rdata_r >> off) & nmask;
  assign wr_en   = cmd.step && is_wr && in_cap;
  assign rd_en   = cmd.issue || cmd.step;
  assign rd_addr = cmd.step ? AW'(idx + IW'(1)) : AW'(idx);
  assign cnt_sat = (in_bit_count > CNT_WIDTH'(MAX_BITS)) ? CNT_WIDTH'(MAX_BITS) : in_bit_count;

  assign st = '{done:     !(is_wr || is_rd) || (rem_r == '0) || err_r,
                out_free: !out_valid_r || out_ready};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(idx)] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r   <= OP_CLEAR;
      rem_r  <= '0;
      err_r  <= 1'b0;
      wpos_r <= '0;
      rpos_r <= '0;
      used_r <= '0;
    end else if (cmd.load) begin
      op_r  <= in_operation;
      val_r <= in_value;
      rem_r <= cnt_sat;
      got_r <= '0;
      rv_r  <= '0;
      err_r <= 1'b0;
      unique case (in_operation)
        OP_ALIGN_WR: wpos_r <= round_up8(wpos_r);
        OP_ALIGN_RD: rpos_r <= round_up8(rpos_r);
        OP_RESET_WR: wpos_r <= '0;
        OP_RESET_RD: rpos_r <= '0;
        OP_CLEAR: begin
          used_r <= '0;
          wpos_r <= '0;
          rpos_r <= '0;
        end
        default: ;
      endcase
    end else if (cmd.step) begin
      if (is_wr) begin
        if (!in_cap) begin
          err_r <= 1'b1;
        end else begin
          if (!in_used) begin
            used_r <= used_r + UW'(1);
          end
          wpos_r <= wpos_r + PW'(n);
          val_r  <= val_r >> n;
          rem_r  <= rem_r - CNT_WIDTH'(n);
        end
      end else begin
        if (!in_used) begin
          err_r <= 1'b1;
        end else begin
          rv_r   <= rv_r | (VAL_WIDTH'(rd_bits) << got_r);
          got_r  <= got_r + CNT_WIDTH'(n);
          rpos_r <= rpos_r + PW'(n);
          rem_r  <= rem_r - CNT_WIDTH'(n);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_rv_r   <= rv_r;
      out_err_r  <= err_r;
      out_wpos_r <= POS_WIDTH'(wpos_r);
      out_rpos_r <= POS_WIDTH'(rpos_r);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_read_value     = out_rv_r;
  assign out_error          = out_err_r;
  assign out_write_position = out_wpos_r;
  assign out_read_position  = out_rpos_r;

`ifndef SYNTH
  a_used_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (IW'(used_r) <= IW'(BUF_BYTES)))
    else $error("used byte count beyond capacity");

  a_wpos_in_used: assert property (@(posedge clk) disable iff (!rst_n)
    (wpos_r <= {IW'(used_r), 3'b000}))
    else $error("write position beyond used bytes");

  a_rpos_in_used: assert property (@(posedge clk) disable iff (!rst_n)
    (rpos_r <= {IW'(used_r), 3'b000}))
    else $error("read position beyond used bytes");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (rem_r <= CNT_WIDTH'(MAX_BITS)))
    else $error("remaining bit count above word size");

  a_emit_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result overwrites a word not yet taken");
`endif

endmodule

FILE: tb/tb_lsb_first_bit_stream_buffer_top.sv
module tb_lsb_first_bit_stream_buffer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lbsb_pkg::*;

  localparam int BUF_BYTES = 256;
  localparam logic [OP_WIDTH-1:0] OP_UNUSED = 3'd7;

  typedef struct packed {
    logic [VAL_WIDTH-1:0] read_value;
    logic                 error;
    logic [POS_WIDTH-1:0] write_position;
    logic [POS_WIDTH-1:0] read_position;
  } bitbuf_result_t;

  typedef struct {
    logic [OP_WIDTH-1:0]  op;
    logic [VAL_WIDTH-1:0] value;
    logic [CNT_WIDTH-1:0] count;
    bit                   fixed;
    logic [VAL_WIDTH-1:0] want_value;
    logic                 want_error;
    logic [POS_WIDTH-1:0] want_wpos;
    logic [POS_WIDTH-1:0] want_rpos;
  } directed_row_t;

  localparam int NUM_DIRECTED = 25;

  // Rows with the fixed flag carry their result; the rest follow the shadow buffer.
  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{OP_READ,     32'h0000_0000, 6'd8,  1'b1, 32'h0000_0000, 1'b1, 12'd0,  12'd0},
    '{OP_WRITE,    32'hFFFF_FFFF, 6'd32, 1'b1, 32'h0000_0000, 1'b0, 12'd32, 12'd0},
    '{OP_READ,     32'h0000_0000, 6'd63, 1'b1, 32'hFFFF_FFFF, 1'b0, 12'd32, 12'd32},
    '{OP_READ,     32'h0000_0000, 6'd1,  1'b1, 32'h0000_0000, 1'b1, 12'd32, 12'd32},
    '{OP_WRITE,    32'h0000_0005, 6'd3,  1'b0, 32'h0, 1'b0, 12'd0, 12'd0},
    '{OP_ALIGN_WR, 32'h0000_0000, 6'd0,  1'b0, 32'h0, 1'b0, 12'd0, 12'd0},
    '{OP_ALIGN_WR, 32'hFFFF_FFFF, 6'd63, 1'b0, 32'h0, 1'b0, 12'd0, 12'd0},
    '{OP_READ,     32'h0000_0000, 6'd0,  1'b0, 32'h0, 1'b0, 12'd0, 12'd0},
    '{OP_READ,     32'h0000_0000, 6'd5,  1'b0, 32'h0, 1'b0, 12'd0, 12'd0},
    '{OP_ALIGN_RD, 32'h0000_0000, 6'd0,  1'b0, 32'h0, 1'b0, 12'd0, 12'd0},
    '{OP_ALIGN_RD, 32'h0000_0000, 6'd0,  1'b0, 32'h0, 1'b0, 12'd0, 12'd0},
    '{OP_RESET_WR, 32'h0000_0000, 6'd0,  1'b0, 32'h0, 1'b0, 12'd0, 12'd0},
    '{OP_WRITE,    32'hA5A5_A5A5, 6'd16, 1'b0, 32'h0, 1'b0, 12'd0, 12'd0},
    '{OP_WRITE,    32'hFFFF_FFFF, 6'd0,  1'b0, 32'h0, 1'b0, 12'd0, 12'd0},
    '{OP_RESET_RD, 32'h0000_0000, 6'd0,  1'b0, 32'h0, 1'b0, 12'd0, 12'd0},
    '{OP_READ,     32'h0000_0000, 6'd40, 1'b0, 32'h0, 1'b0, 12'd0, 12'd0},
    '{OP_READ,     32'h0000_0000, 6'd32, 1'b0, 32'h0, 1'b0, 12'd0, 12'd0},
    '{OP_UNUSED,   32'hFFFF_FFFF, 6'd63, 1'b0, 32'h0, 1'b0, 12'd0, 12'd0},
    '{OP_WRITE,    32'h8000_0000, 6'd33, 1'b0, 32'h0, 1'b0, 12'd0, 12'd0},
    '{OP_CLEAR,    32'h0000_0000, 6'd0,  1'b1, 32'h0000_0000, 1'b0, 12'd0,  12'd0},
    '{OP_READ,     32'h0000_0000, 6'd1,  1'b1, 32'h0000_0000, 1'b1, 12'd0,  12'd0},
    '{OP_WRITE,    32'h0000_0001, 6'd1,  1'b0, 32'h0, 1'b0, 12'd0, 12'd0},
    '{OP_ALIGN_WR, 32'h0000_0000, 6'd0,  1'b0, 32'h0, 1'b0, 12'd0, 12'd0},
    '{OP_WRITE,    32'h0000_0001, 6'd1,  1'b0, 32'h0, 1'b0, 12'd0, 12'd0},
    '{OP_READ,     32'h0000_0000, 6'd16, 1'b0, 32'h0, 1'b0, 12'd0, 12'd0}
  };

  logic clk;
  logic rst_n;

  lbsb_in_if  in_ch ();
  lbsb_out_if out_ch ();

  lsb_first_bit_stream_buffer_top #(
    .BUF_BYTES(BUF_BYTES)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  logic [7:0]     shadow_store [BUF_BYTES];
  int unsigned    shadow_used;
  int unsigned    shadow_wpos;
  int unsigned    shadow_rpos;
  bitbuf_result_t awaited_results [$];

  int mismatches;
  int words_sent;
  int words_checked;
  int burst_left;
  int op_counts [8];
  int write_overflows;
  int read_underruns;
  int peak_wpos;

  int          ready_mode;
  int          ready_mode_left;
  int unsigned ready_cycle;

  function automatic bitbuf_result_t shadow_apply(logic [OP_WIDTH-1:0] op,
                                                  logic [VAL_WIDTH-1:0] val,
                                                  logic [CNT_WIDTH-1:0] cnt_in);
    bitbuf_result_t r;
    int unsigned    cnt;
    int unsigned    idx;
    int unsigned    i;
    bit             stop;
    r = '0;
    stop = 1'b0;
    cnt = (cnt_in > MAX_BITS) ? MAX_BITS : cnt_in;
    case (op)
      OP_WRITE: begin
        for (i = 0; i < cnt && !stop; i++) begin
          idx = shadow_wpos >> 3;
          if (idx >= BUF_BYTES) begin
            r.error = 1'b1;
            stop = 1'b1;
          end else begin
            while (shadow_used <= idx) begin
              shadow_store[shadow_used] = 8'h00;
              shadow_used++;
            end
            if (val[i]) shadow_store[idx][shadow_wpos % 8] = 1'b1;
            shadow_wpos++;
          end
        end
      end
      OP_READ: begin
        for (i = 0; i < cnt && !stop; i++) begin
          idx = shadow_rpos >> 3;
          if (idx >= shadow_used || idx >= BUF_BYTES) begin
            r.error = 1'b1;
            stop = 1'b1;
          end else begin
            r.read_value[i] = shadow_store[idx][shadow_rpos % 8];
            shadow_rpos++;
          end
        end
      end
      OP_ALIGN_WR: shadow_wpos = (shadow_wpos + 7) & ~32'd7;
      OP_ALIGN_RD: shadow_rpos = (shadow_rpos + 7) & ~32'd7;
      OP_RESET_WR: shadow_wpos = 0;
      OP_RESET_RD: shadow_rpos = 0;
      OP_CLEAR: begin
        shadow_used = 0;
        shadow_wpos = 0;
        shadow_rpos = 0;
      end
      default: ;
    endcase
    r.write_position = 12'(shadow_wpos);
    r.read_position  = 12'(shadow_rpos);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  task automatic check_result_word();
    bitbuf_result_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch("result word with nothing awaited", out_ch.read_value, 32'h0);
    end else begin
      want = awaited_results.pop_front();
      words_checked++;
      if (out_ch.read_value !== want.read_value)
        report_mismatch("read_value", out_ch.read_value, want.read_value);
      if (out_ch.error !== want.error)
        report_mismatch("error", 32'(out_ch.error), 32'(want.error));
      if (out_ch.write_position !== want.write_position)
        report_mismatch("write_position", 32'(out_ch.write_position),
                        32'(want.write_position));
      if (out_ch.read_position !== want.read_position)
        report_mismatch("read_position", 32'(out_ch.read_position),
                        32'(want.read_position));
    end
  endtask

  task automatic send_word(logic [OP_WIDTH-1:0] op, logic [VAL_WIDTH-1:0] val,
                           logic [CNT_WIDTH-1:0] cnt, bit fixed, bitbuf_result_t fixed_want);
    int             gap;
    bitbuf_result_t predicted;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.value     <= val;
    in_ch.bit_count <= cnt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = shadow_apply(op, val, cnt);
    awaited_results.insert(awaited_results.size(), fixed ? fixed_want : predicted);
    burst_left--;
    words_sent++;
    op_counts[op]++;
    if (op == OP_WRITE && predicted.error) write_overflows++;
    if (op == OP_READ && predicted.error) read_underruns++;
    if (shadow_wpos > peak_wpos) peak_wpos = shadow_wpos;
  endtask

  task automatic send_random_word(int kind);
    int unsigned          roll;
    logic [OP_WIDTH-1:0]  op;
    logic [CNT_WIDTH-1:0] cnt;
    roll = $urandom_range(0, 99);
    cnt = ($urandom_range(0, 9) == 0) ? CNT_WIDTH'($urandom_range(33, 63))
                                      : CNT_WIDTH'($urandom_range(0, 32));
    case (kind)
      0: begin
        if (roll < 85) begin
          op = OP_WRITE;
          cnt = CNT_WIDTH'($urandom_range(24, 63));
        end else if (roll < 93) begin
          op = OP_READ;
        end else begin
          op = OP_WIDTH'($urandom_range(OP_ALIGN_WR, OP_RESET_RD));
        end
      end
      1: begin
        if (roll < 40) op = OP_WRITE;
        else if (roll < 75) op = OP_READ;
        else if (roll < 83) op = OP_WIDTH'($urandom_range(OP_ALIGN_WR, OP_ALIGN_RD));
        else if (roll < 90) op = OP_WIDTH'($urandom_range(OP_RESET_WR, OP_RESET_RD));
        else if (roll < 93) op = OP_CLEAR;
        else op = OP_UNUSED;
      end
      2: begin
        if (roll < 20) op = OP_WRITE;
        else if (roll < 80) op = OP_READ;
        else if (roll < 92) op = OP_ALIGN_RD;
        else op = OP_RESET_RD;
      end
      default: begin
        op = OP_WIDTH'($urandom_range(0, 7));
        cnt = CNT_WIDTH'($urandom_range(0, 63));
      end
    endcase
    send_word(op, $urandom, cnt, 1'b0, '0);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (ready_mode_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_mode_left = $urandom_range(50, 300);
    end else begin
      ready_mode_left--;
    end
    ready_cycle++;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      case (ready_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 9) < 7);
        2: out_ch.ready <= ((ready_cycle % 8) < 5);
        default: out_ch.ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
    if (rst_n && out_ch.valid && out_ch.ready) check_result_word();
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    bitbuf_result_t fixed_want;
    int             kind;
    int             length;
    int             n;
    int             drain_wait;
    mismatches = 0;
    words_sent = 0;
    words_checked = 0;
    burst_left = 0;
    write_overflows = 0;
    read_underruns = 0;
    peak_wpos = 0;
    ready_mode = 0;
    ready_mode_left = 0;
    ready_cycle = 0;
    foreach (op_counts[k]) op_counts[k] = 0;
    foreach (shadow_store[k]) shadow_store[k] = 8'h00;
    shadow_used = 0;
    shadow_wpos = 0;
    shadow_rpos = 0;

    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_WRITE;
    in_ch.value = '0;
    in_ch.bit_count = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      fixed_want.read_value     = directed_rows[r].want_value;
      fixed_want.error          = directed_rows[r].want_error;
      fixed_want.write_position = directed_rows[r].want_wpos;
      fixed_want.read_position  = directed_rows[r].want_rpos;
      send_word(directed_rows[r].op, directed_rows[r].value, directed_rows[r].count,
                directed_rows[r].fixed, fixed_want);
    end

    // The first episode leans heavily on writes so the store usually fills to capacity.
    kind = 0;
    while (words_sent < NUM_DIRECTED + 1600) begin
      if ($urandom_range(0, 1) == 0)
        send_word(OP_CLEAR, $urandom, CNT_WIDTH'($urandom_range(0, 63)), 1'b0, '0);
      length = (kind == 0) ? 130 : $urandom_range(20, 80);
      for (n = 0; n < length; n++) send_random_word(kind);
      n = $urandom_range(0, 99);
      kind = (n < 20) ? 0 : (n < 60) ? 1 : (n < 85) ? 2 : 3;
    end
    in_ch.valid <= 1'b0;

    drain_wait = 0;
    while (awaited_results.size() != 0 && drain_wait < 20000) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (20) @(posedge clk);
    if (awaited_results.size() != 0)
      report_mismatch("result words never delivered", awaited_results.size(), 32'h0);

    $display("Sent %0d words, checked %0d results: %0d writes, %0d reads, %0d others.",
             words_sent, words_checked, op_counts[OP_WRITE], op_counts[OP_READ],
             words_sent - op_counts[OP_WRITE] - op_counts[OP_READ]);
    $display("Capacity overflows %0d, reads past used bytes %0d, peak write position %0d.",
             write_overflows, read_underruns, peak_wpos);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
